@@ rtl/tkv_pkg.sv @@
// Shared types, widths and constants of the tachometer and KV meter.
package tkv_pkg;

  // Averaging depths
  localparam int unsigned PERIOD_AVG_COUNT = 10;
  localparam int unsigned VOLT_AVG_COUNT   = 40;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned VOLT_W  = 20;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned TIRE_W  = 20;
  localparam int unsigned RPM24_W = 24;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned MV_W    = 14;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned DIAM_W  = 8;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USED_W = TIRE_W + 3 * RPM24_W + SPEED_W + MV_W;

  // Shift-add multiplier: A operand in parallel, B operand one bit per cycle
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 20;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);

  // Restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_N_W = 46;
  localparam int unsigned DIV_D_W = 32;
  localparam int unsigned DIV_L_W = $clog2(DIV_N_W + 1);

  // Arithmetic constants
  localparam logic [TIRE_W-1:0]  TIRE_RPM_MAX = 20'd999999;
  localparam logic [RPM24_W-1:0] MAX24        = 24'hFF_FFFF;
  localparam logic [SPEED_W-1:0] MAX16        = 16'hFFFF;
  localparam int unsigned RPM_NUM      = 60000000;  // us per minute
  localparam int unsigned RPM_NUM_W    = 26;
  localparam int unsigned GEAR_DEN     = 1000;
  localparam int unsigned SPEED_K      = 188490;    // 31415 * 6
  localparam int unsigned SPEED_DEN    = 10000000;
  localparam int unsigned ADC_TO_VOLT  = 136;       // 8.5 * 65536 / 4096
  localparam int unsigned MV_SCALE     = 1000;

  // Configuration register indexes
  localparam logic [1:0] REG_IGNORE = 2'd0;
  localparam logic [1:0] REG_GEAR   = 2'd1;
  localparam logic [1:0] REG_DIAM   = 2'd2;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } tkv_mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;  // left aligned
    logic [DIV_D_W-1:0] den;
    logic [DIV_L_W-1:0] len;  // numerator bits to process
  } tkv_div_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PCHK,
    S_PMUL,
    S_PDIV,
    S_VMUL1,
    S_VMUL2,
    S_VDIV,
    S_TIRE,
    S_MMUL,
    S_MDIV,
    S_KVDIV,
    S_TMUL,
    S_TDIV,
    S_SMUL1,
    S_SMUL2,
    S_SDIV,
    S_MV,
    S_EMIT
  } tkv_state_e;

endpackage

@@ rtl/tkv_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module tkv_mul import tkv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tkv_mul_req_t       req_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_P_W-1:0]   p_q;
  logic [MUL_A_W:0]     sum;

  // Add the multiplicand into the upper half when the current multiplier bit is set
  assign sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CNT_W'(MUL_B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      p_q <= {{MUL_A_W{1'b0}}, req_i.b};
    end else if (busy_q) begin
      p_q <= {sum, p_q[MUL_B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ rtl/tkv_div.sv @@
// Restoring divider, one quotient bit per cycle over a left-aligned numerator.
module tkv_div import tkv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tkv_div_req_t       req_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DIV_L_W-1:0] cnt_q;
  logic [DIV_D_W-1:0] den_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_N_W-1:0] q_q;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  // Bring down the next numerator bit and try to subtract the divisor
  assign trial = {rem_q, q_q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.len;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_L_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Numerator bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= '0;
      q_q   <= req_i.num;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      q_q   <= {q_q[DIV_N_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

@@ rtl/tachometer_kv_meter.sv @@
// Tachometer and KV meter: pulse period and battery voltage averaging with rpm/KV results.
//
// Each input beat is either a rotation pulse (tuser = 0) carrying a microsecond
// timestamp, or a battery ADC sample (tuser = 1). A pulse no farther than
// ignore_interval_us from the last kept pulse (wrapping difference) is dropped.
// A kept pulse updates the period average d = (9d + delta) / 10, and every
// tenth kept pulse produces one output beat with tire rpm, motor rpm, KV,
// KVT x10, speed x100 and battery millivolts; tuser flags a zero battery
// average, in which case both per-volt fields read all ones. All results
// saturate at their field maximum. ADC samples update the voltage average
// v = (39v + 136 * adc) / 40 in units of 2^-16 V and never produce a beat.
// The block works on one beat at a time: all arithmetic runs through one
// bit-serial shift-add multiplier and one restoring divider. The output
// beat sits in its own register, so a new input beat is taken while a
// finished result still waits for m_axis_tready. Configuration writes are
// registered and must only be made while the block is idle.
module tachometer_kv_meter import tkv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // time_us[31:0], adc_sample[43:32], zero pad
  input  logic                  s_axis_tuser,   // action
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // tire_rpm[19:0], motor_rpm[43:20],
                                                // kv_value[67:44], kvt_x10[91:68],
                                                // speed_x100[107:92], battery_mv[121:108],
                                                // zero pad
  output logic                  m_axis_tuser,   // voltage_zero
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  // Control state
  tkv_state_e state_q, state_d;
  logic       issue_q, issue_d;  // request already issued to the shared unit

  // Configuration
  logic [CFG_W-1:0]  ignore_q;
  logic [CFG_W-1:0]  gear_q;
  logic [DIAM_W-1:0] diam_q;

  // Averaging state
  logic [TIME_W-1:0] last_q;
  logic [TIME_W-1:0] period_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [VOLT_W-1:0] volt_q;

  // Captured input beat and working registers
  logic [TIME_W-1:0]   t_q;
  logic [ADC_W-1:0]    adc_q;
  logic [25:0]         tmp_q;
  logic [DIV_N_W-1:0]  num_q;
  logic [TIRE_W-1:0]   tire_q;
  logic [RPM24_W-1:0]  motor_q;
  logic [RPM24_W-1:0]  kv_q;
  logic [RPM24_W-1:0]  kvt_q;
  logic [SPEED_W-1:0]  speed_q;

  // Output register
  logic                  out_valid_q;
  logic [OUT_USED_W-1:0] out_data_q;
  logic                  out_vz_q;

  // Shared arithmetic units
  tkv_mul_req_t       mul_req;
  tkv_div_req_t       div_req;
  logic               mul_done;
  logic               div_done;
  logic [MUL_P_W-1:0] prod;
  logic [DIV_N_W-1:0] quot;

  logic [TIME_W-1:0] delta;
  logic              emit_ok;
  logic              in_beat;

  tkv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  tkv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Wrapping spacing from the last kept pulse
  assign delta   = t_q - last_q;
  assign emit_ok = !out_valid_q || m_axis_tready;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
    end
  end

  // Sequencer: each arithmetic state issues one request and waits for its done
  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = s_axis_tuser ? S_VMUL1 : S_PCHK;
        end
      end
      S_PCHK: begin
        state_d = (delta <= {{(TIME_W-CFG_W){1'b0}}, ignore_q}) ? S_IDLE : S_PMUL;
      end
      S_PMUL: begin
        mul_req.start = !issue_q;
        mul_req.a     = period_q;
        mul_req.b     = MUL_B_W'(PERIOD_AVG_COUNT - 1);
        if (mul_done) state_d = S_PDIV;
      end
      S_PDIV: begin
        div_req.start = !issue_q;
        div_req.num   = {num_q[35:0], 10'b0};
        div_req.den   = DIV_D_W'(PERIOD_AVG_COUNT);
        div_req.len   = DIV_L_W'(36);
        if (div_done) begin
          state_d = (cnt_q == CNT_W'(PERIOD_AVG_COUNT - 1)) ? S_TIRE : S_IDLE;
        end
      end
      S_VMUL1: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(volt_q);
        mul_req.b     = MUL_B_W'(VOLT_AVG_COUNT - 1);
        if (mul_done) state_d = S_VMUL2;
      end
      S_VMUL2: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(adc_q);
        mul_req.b     = MUL_B_W'(ADC_TO_VOLT);
        if (mul_done) state_d = S_VDIV;
      end
      S_VDIV: begin
        div_req.start = !issue_q;
        div_req.num   = {num_q[26:0], 19'b0};
        div_req.den   = DIV_D_W'(VOLT_AVG_COUNT);
        div_req.len   = DIV_L_W'(27);
        if (div_done) state_d = S_IDLE;
      end
      S_TIRE: begin
        // A zero period divides to all ones and saturates like any large quotient
        div_req.start = !issue_q;
        div_req.num   = {RPM_NUM_W'(RPM_NUM), {(DIV_N_W-RPM_NUM_W){1'b0}}};
        div_req.den   = period_q;
        div_req.len   = DIV_L_W'(RPM_NUM_W);
        if (div_done) state_d = S_MMUL;
      end
      S_MMUL: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(gear_q);
        mul_req.b     = tire_q;
        if (mul_done) state_d = S_MDIV;
      end
      S_MDIV: begin
        div_req.start = !issue_q;
        div_req.num   = {num_q[35:0], 10'b0};
        div_req.den   = DIV_D_W'(GEAR_DEN);
        div_req.len   = DIV_L_W'(36);
        if (div_done) state_d = S_KVDIV;
      end
      S_KVDIV: begin
        div_req.start = !issue_q;
        div_req.num   = {motor_q, 16'b0, 6'b0};
        div_req.den   = DIV_D_W'(volt_q);
        div_req.len   = DIV_L_W'(40);
        if (div_done) state_d = S_TMUL;
      end
      S_TMUL: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(tire_q);
        mul_req.b     = MUL_B_W'(10);
        if (mul_done) state_d = S_TDIV;
      end
      S_TDIV: begin
        div_req.start = !issue_q;
        div_req.num   = {tmp_q[23:0], 16'b0, 6'b0};
        div_req.den   = DIV_D_W'(volt_q);
        div_req.len   = DIV_L_W'(40);
        if (div_done) state_d = S_SMUL1;
      end
      S_SMUL1: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(SPEED_K);
        mul_req.b     = MUL_B_W'(diam_q);
        if (mul_done) state_d = S_SMUL2;
      end
      S_SMUL2: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(tmp_q);
        mul_req.b     = tire_q;
        if (mul_done) state_d = S_SDIV;
      end
      S_SDIV: begin
        div_req.start = !issue_q;
        div_req.num   = num_q;
        div_req.den   = DIV_D_W'(SPEED_DEN);
        div_req.len   = DIV_L_W'(DIV_N_W);
        if (div_done) state_d = S_MV;
      end
      S_MV: begin
        mul_req.start = !issue_q;
        mul_req.a     = MUL_A_W'(volt_q);
        mul_req.b     = MUL_B_W'(MV_SCALE);
        if (mul_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (emit_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (mul_req.start || div_req.start) issue_d = 1'b1;
    if (mul_done || div_done)           issue_d = 1'b0;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_q <= CFG_W'(7000);
      gear_q   <= CFG_W'(6989);
      diam_q   <= DIAM_W'(63);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IGNORE: ignore_q <= cfg_wdata_i;
        REG_GEAR:   gear_q   <= cfg_wdata_i;
        REG_DIAM:   diam_q   <= cfg_wdata_i[DIAM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Averaging state: period, last pulse time, pulse count, voltage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      period_q <= TIME_W'(1);
      cnt_q    <= '0;
      volt_q   <= '0;
    end else begin
      if (state_q == S_PDIV && div_done) begin
        period_q <= quot[TIME_W-1:0];
        last_q   <= t_q;
        cnt_q    <= (cnt_q == CNT_W'(PERIOD_AVG_COUNT - 1)) ? '0 : cnt_q + 1'b1;
      end
      if (state_q == S_VDIV && div_done) begin
        volt_q <= quot[VOLT_W-1:0];
      end
    end
  end

  // Working registers, loaded from the input beat, as each product or quotient completes, and on emit
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      t_q   <= s_axis_tdata[TIME_W-1:0];
      adc_q <= s_axis_tdata[TIME_W+ADC_W-1:TIME_W];
    end
    if (mul_done) begin
      unique case (state_q)
        S_PMUL:  num_q <= DIV_N_W'(prod[35:0]) + DIV_N_W'(delta);
        S_VMUL1: tmp_q <= prod[25:0];
        S_VMUL2: num_q <= DIV_N_W'(tmp_q) + DIV_N_W'(prod[19:0]);
        S_MMUL:  num_q <= prod[DIV_N_W-1:0];
        S_TMUL:  tmp_q <= prod[25:0];
        S_SMUL1: tmp_q <= prod[25:0];
        S_SMUL2: num_q <= prod[DIV_N_W-1:0];
        default: ;
      endcase
    end
    if (div_done) begin
      unique case (state_q)
        S_TIRE: begin
          tire_q <= (quot > DIV_N_W'(TIRE_RPM_MAX)) ? TIRE_RPM_MAX : quot[TIRE_W-1:0];
        end
        S_MDIV: begin
          motor_q <= (quot > DIV_N_W'(MAX24)) ? MAX24 : quot[RPM24_W-1:0];
        end
        S_KVDIV: begin
          kv_q <= (quot > DIV_N_W'(MAX24)) ? MAX24 : quot[RPM24_W-1:0];
        end
        S_TDIV: begin
          kvt_q <= (quot > DIV_N_W'(MAX24)) ? MAX24 : quot[RPM24_W-1:0];
        end
        S_SDIV: begin
          speed_q <= (quot > DIV_N_W'(MAX16)) ? MAX16 : quot[SPEED_W-1:0];
        end
        default: ;
      endcase
    end
    if (state_q == S_EMIT && emit_ok) begin
      // Millivolts come straight from the last product: v * 1000 >> 16
      out_data_q <= {prod[MV_W+15:16], speed_q, kvt_q, kv_q, motor_q, tire_q};
      out_vz_q   <= (volt_q == '0);
    end
  end

  // Output valid: set when a result is loaded, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_data_q};
  assign m_axis_tuser  = out_vz_q;

  // The two shared units are never started together
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started in the same cycle");

  // The pulse count wraps before reaching the averaging depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(PERIOD_AVG_COUNT))
    else $error("pulse count out of range");

  // A new output beat only appears out of the emit state
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_EMIT)
    else $error("output valid raised outside the emit state");

  // A finished result waits while the previous one is stalled
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && m_axis_tvalid && !m_axis_tready) |=> state_q == S_EMIT)
    else $error("result overwrote a stalled output beat");

endmodule
